FILE: rtl/reflect_refract_vector_unit_macros.svh
// Assertion macros for the reflect/refract vector unit checker
`ifndef REFLECT_REFRACT_VECTOR_UNIT_MACROS_SVH
`define REFLECT_REFRACT_VECTOR_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define RRV_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define RRV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, always on
`define RRV_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/rrv_pkg.sv
// Package: widths, pipeline types and fixed-point helpers of the vector unit
package rrv_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COMP_W    = 16;
    localparam int ACC_W     = COMP_W + 4;
    localparam int MUL_W     = ACC_W + 1;
    localparam int SUM_W     = ACC_W + 3;
    localparam int NRM_W     = COMP_W + 1;
    localparam int RT_W      = (ACC_W - 1 + FRAC_BITS + 1) / 2;
    localparam int RAD_W     = 2 * RT_W;
    localparam int REM_W     = RT_W + 3;
    localparam int SQ_PER    = 3;
    localparam int SQ_STG    = (RT_W + SQ_PER - 1) / SQ_PER;
    localparam int ST_SQ0    = 5;
    localparam int ST_M      = ST_SQ0 + SQ_STG;
    localparam int ST_MP     = ST_M + 1;
    localparam int ST_OUT    = ST_MP + 1;
    localparam int NSTG      = ST_OUT + 1;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [NRM_W-1:0]  t_nrm;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [MUL_W-1:0]  t_mul;
    typedef logic signed [SUM_W-1:0]  t_sum;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ONE = (FRAC_BITS >= ACC_W - 1) ? ACC_MAX : (t_acc'(1) << FRAC_BITS);
    localparam logic [2*MUL_W-1:0] HALF = (2*MUL_W)'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [RT_W-1:0]  root;
        logic [RAD_W-1:0] rad;
    } t_sq;

    typedef struct packed {
        logic            mode;
        t_comp [2:0]     inc;
        t_nrm  [2:0]     nrm;
        logic [COMP_W-1:0] eta;
        t_acc  [2:0]     pd;
        t_acc  [2:0]     ei;
        t_acc            e2;
        t_acc            d;
        t_mul            c;
        t_acc            t;
        t_acc            cc;
        t_acc            ec;
        t_acc  [2:0]     rp;
        t_acc            p;
        t_acc            k;
        t_sq             sq;
        t_acc            m;
        t_acc  [2:0]     mp;
        t_comp [2:0]     res;
        logic            ntr;
    } t_pipe;

    // sign-magnitude product, ties rounded toward +inf, saturate
    function automatic t_acc fx_mul(input t_mul a, input t_mul b);
        logic               neg;
        logic [MUL_W-1:0]   ua;
        logic [MUL_W-1:0]   ub;
        logic [2*MUL_W-1:0] p;
        logic [2*MUL_W-1:0] q;
        logic [ACC_W-1:0]   lim;
        logic [ACC_W-1:0]   m;
        neg = a[MUL_W-1] ^ b[MUL_W-1];
        ua  = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
        ub  = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
        p   = (2*MUL_W)'(ua) * (2*MUL_W)'(ub);
        q   = (p + (neg ? HALF - 1'b1 : HALF)) >> FRAC_BITS;
        lim = neg ? (ACC_W'(1) << (ACC_W - 1)) : ACC_MAX;
        m   = (q > (2*MUL_W)'(lim)) ? lim : q[ACC_W-1:0];
        return neg ? t_acc'(-m) : t_acc'(m);
    endfunction

    function automatic t_acc sat_acc(input t_sum v);
        t_sum hi;
        t_sum lo;
        hi = t_sum'(ACC_MAX);
        lo = ~hi;
        if (v > hi) return ACC_MAX;
        if (v < lo) return ~ACC_MAX;
        return v[ACC_W-1:0];
    endfunction

    function automatic t_comp sat_comp(input t_sum v);
        t_sum hi;
        t_sum lo;
        hi = t_sum'({1'b0, {(COMP_W-1){1'b1}}});
        lo = ~hi;
        if (v > hi) return hi[COMP_W-1:0];
        if (v < lo) return lo[COMP_W-1:0];
        return v[COMP_W-1:0];
    endfunction

endpackage

FILE: rtl/rrv_sqrt_step.sv
// One digit step of the restoring integer square root
module rrv_sqrt_step (
    input  logic         i_act,
    input  rrv_pkg::t_sq i_sq,
    output rrv_pkg::t_sq o_sq
);
    import rrv_pkg::*;

    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;

    always_comb begin
        rem2  = {i_sq.rem[REM_W-3:0], i_sq.rad[RAD_W-1:RAD_W-2]};
        trial = REM_W'({i_sq.root, 2'b01});
        o_sq  = i_sq;
        if (i_act) begin
            o_sq.rad = i_sq.rad << 2;
            if (rem2 >= trial) begin
                o_sq.rem  = rem2 - trial;
                o_sq.root = {i_sq.root[RT_W-2:0], 1'b1};
            end else begin
                o_sq.rem  = rem2;
                o_sq.root = {i_sq.root[RT_W-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: rtl/reflect_refract_vector_unit.sv
// Throughput: one item per cycle unless stalled; 6-stage pipelined square root sets the depth.
// Each stage holds its item while the next stage is full and not moving.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
// Top level of the reflect/refract vector unit
module reflect_refract_vector_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_mode,
    input  logic signed [15:0]       i_inc_x,
    input  logic signed [15:0]       i_inc_y,
    input  logic signed [15:0]       i_inc_z,
    input  logic signed [15:0]       i_nrm_x,
    input  logic signed [15:0]       i_nrm_y,
    input  logic signed [15:0]       i_nrm_z,
    input  logic [15:0]              i_eta,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [15:0]       o_out_x,
    output logic signed [15:0]       o_out_y,
    output logic signed [15:0]       o_out_z,
    output logic                     o_no_transmission
);
    import rrv_pkg::*;

    t_pipe r_st [NSTG];
    t_pipe n_st [NSTG];
    logic  r_vld [NSTG];
    logic  rdy   [NSTG];
    t_sq   sq_link [SQ_STG][SQ_PER+1];

    for (genvar g = 0; g < SQ_STG; g++) begin : g_sq
        assign sq_link[g][0] = r_st[ST_SQ0+g-1].sq;
        for (genvar j = 0; j < SQ_PER; j++) begin : g_step
            rrv_sqrt_step u_step (
                .i_act ((g * SQ_PER + j) < RT_W),
                .i_sq  (sq_link[g][j]),
                .o_sq  (sq_link[g][j+1])
            );
        end
    end

    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            rdy[s] = !r_vld[s] || rdy[s+1];
        end
    end

    always_comb begin
        logic flip;
        t_acc kv;
        t_acc u;
        // stage 0: input capture and first products
        n_st[0]        = '0;
        n_st[0].mode   = i_mode;
        n_st[0].inc[0] = i_inc_x;
        n_st[0].inc[1] = i_inc_y;
        n_st[0].inc[2] = i_inc_z;
        n_st[0].nrm[0] = t_nrm'(i_nrm_x);
        n_st[0].nrm[1] = t_nrm'(i_nrm_y);
        n_st[0].nrm[2] = t_nrm'(i_nrm_z);
        n_st[0].eta    = i_eta;
        for (int j = 0; j < 3; j++) begin
            n_st[0].pd[j] = fx_mul(t_mul'(n_st[0].inc[j]), t_mul'(n_st[0].nrm[j]));
            n_st[0].ei[j] = fx_mul(t_mul'(i_eta), t_mul'(n_st[0].inc[j]));
        end
        n_st[0].e2 = fx_mul(t_mul'(i_eta), t_mul'(i_eta));

        // stage 1: dot product, facing fix-up
        n_st[1]   = r_st[0];
        n_st[1].d = sat_acc(t_sum'(r_st[0].pd[0]) + t_sum'(r_st[0].pd[1])
                            + t_sum'(r_st[0].pd[2]));
        flip = r_st[0].mode && !n_st[1].d[ACC_W-1] && (n_st[1].d != '0);
        n_st[1].c = n_st[1].d[ACC_W-1] ? -t_mul'(n_st[1].d) : t_mul'(n_st[1].d);
        n_st[1].t = sat_acc(-(t_sum'(n_st[1].d) + t_sum'(n_st[1].d)));
        for (int j = 0; j < 3; j++) begin
            if (flip) n_st[1].nrm[j] = -r_st[0].nrm[j];
        end

        // stage 2
        n_st[2]    = r_st[1];
        n_st[2].cc = fx_mul(r_st[1].c, r_st[1].c);
        n_st[2].ec = fx_mul(t_mul'(r_st[1].eta), r_st[1].c);
        for (int j = 0; j < 3; j++) begin
            n_st[2].rp[j] = fx_mul(t_mul'(r_st[1].nrm[j]), t_mul'(r_st[1].t));
        end

        // stage 3
        n_st[3]   = r_st[2];
        u         = sat_acc(t_sum'(ONE) - t_sum'(r_st[2].cc));
        n_st[3].p = fx_mul(t_mul'(r_st[2].e2), t_mul'(u));

        // stage 4: k and root setup
        n_st[4]         = r_st[3];
        kv              = sat_acc(t_sum'(ONE) - t_sum'(r_st[3].p));
        n_st[4].k       = kv;
        n_st[4].sq.rem  = '0;
        n_st[4].sq.root = '0;
        n_st[4].sq.rad  = RAD_W'($unsigned(kv)) << FRAC_BITS;

        for (int g = 0; g < SQ_STG; g++) begin
            n_st[ST_SQ0+g]    = r_st[ST_SQ0+g-1];
            n_st[ST_SQ0+g].sq = sq_link[g][SQ_PER];
        end

        n_st[ST_M]   = r_st[ST_M-1];
        n_st[ST_M].m = sat_acc(t_sum'(r_st[ST_M-1].ec) - t_sum'(r_st[ST_M-1].sq.root));

        n_st[ST_MP] = r_st[ST_MP-1];
        for (int j = 0; j < 3; j++) begin
            n_st[ST_MP].mp[j] = fx_mul(t_mul'(r_st[ST_MP-1].m), t_mul'(r_st[ST_MP-1].nrm[j]));
        end

        // output stage
        n_st[ST_OUT]     = r_st[ST_OUT-1];
        n_st[ST_OUT].ntr = r_st[ST_OUT-1].mode && r_st[ST_OUT-1].k[ACC_W-1];
        for (int j = 0; j < 3; j++) begin
            if (!r_st[ST_OUT-1].mode) begin
                n_st[ST_OUT].res[j] = sat_comp(t_sum'(r_st[ST_OUT-1].inc[j])
                                               + t_sum'(r_st[ST_OUT-1].rp[j]));
            end else if (r_st[ST_OUT-1].k[ACC_W-1]) begin
                n_st[ST_OUT].res[j] = '0;
            end else begin
                n_st[ST_OUT].res[j] = sat_comp(t_sum'(r_st[ST_OUT-1].ei[j])
                                               + t_sum'(r_st[ST_OUT-1].mp[j]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NSTG; s++) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (rdy[s]) begin
                r_vld[s] <= (s == 0) ? i_valid : r_vld[(s == 0) ? 0 : s - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NSTG; s++) begin
            if (rdy[s]) r_st[s] <= n_st[s];
        end
    end

    assign o_ready           = rdy[0];
    assign o_valid           = r_vld[NSTG-1];
    assign o_out_x           = r_st[NSTG-1].res[0];
    assign o_out_y           = r_st[NSTG-1].res[1];
    assign o_out_z           = r_st[NSTG-1].res[2];
    assign o_no_transmission = r_st[NSTG-1].ntr;
endmodule

FILE: rtl/rrv_checker.sv
// Port-level checker for the vector unit, bound to the top level
`include "reflect_refract_vector_unit_macros.svh"

module rrv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_out_x,
    input logic [15:0] o_out_y,
    input logic [15:0] o_out_z,
    input logic        o_no_transmission
);
    logic out_zero;

    assign out_zero = (o_out_x == 16'd0) && (o_out_y == 16'd0) && (o_out_z == 16'd0);

    `RRV_ASSERT_NEXT_ALWAYS(a_rst_clears, i_clk, !i_rst_n, !o_valid)
    `RRV_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `RRV_ASSERT_SAME(a_tir_zero, i_clk, i_rst_n, o_valid && o_no_transmission, out_zero)
endmodule

bind reflect_refract_vector_unit rrv_checker u_rrv_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_out_x           (o_out_x),
    .o_out_y           (o_out_y),
    .o_out_z           (o_out_z),
    .o_no_transmission (o_no_transmission)
);

FILE: dv/rrv_checker.sv
// Checker for the reflect/refract vector unit: predicts each item's result and compares
`timescale 1ns / 100ps
module rrv_tb_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_ready_in,
    input  logic              i_mode,
    input  logic signed [15:0] i_inc_x,
    input  logic signed [15:0] i_inc_y,
    input  logic signed [15:0] i_inc_z,
    input  logic signed [15:0] i_nrm_x,
    input  logic signed [15:0] i_nrm_y,
    input  logic signed [15:0] i_nrm_z,
    input  logic [15:0]       i_eta,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic signed [15:0] i_out_x,
    input  logic signed [15:0] i_out_y,
    input  logic signed [15:0] i_out_z,
    input  logic              i_no_transmission,
    output int                o_fail_count,
    output int                o_pending
);
    import rrv_pkg::*;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               ntr;
    } t_shade;

    t_shade shade_q[$];

    localparam longint AMAX = (64'sd1 <<< (ACC_W - 1)) - 1;
    localparam longint CMAX = (64'sd1 <<< (COMP_W - 1)) - 1;

    function automatic longint clip(longint v, longint hi);
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // sign-magnitude product, half rounded toward +inf, saturated to the accumulator
    function automatic longint qmul(longint a, longint b);
        logic       neg;
        logic [127:0] p;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        p = (p + (neg ? (128'd1 << (FRAC_BITS - 1)) - 1 : (128'd1 << (FRAC_BITS - 1))))
            >> FRAC_BITS;
        lim = neg ? 128'(AMAX + 1) : 128'(AMAX);
        if (p > lim) p = lim;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint qroot(longint k);
        logic [127:0] rad;
        longint r;
        longint cand;
        rad = 128'(k) << FRAC_BITS;
        r = 0;
        for (int b = 33; b >= 0; b--) begin
            cand = r | (64'sd1 <<< b);
            if (128'(cand) * 128'(cand) <= rad) r = cand;
        end
        return clip(r, AMAX);
    endfunction

    function automatic t_shade shade(logic mode, longint ix, iy, iz, nx, ny, nz, longint eta);
        longint vi[3];
        longint vn[3];
        longint rs[3];
        longint d, t, c, k, m, one;
        t_shade s;
        vi = '{ix, iy, iz};
        vn = '{nx, ny, nz};
        one = clip(64'sd1 <<< FRAC_BITS, AMAX);
        s.ntr = 1'b0;
        d = clip(qmul(vi[0], vn[0]) + qmul(vi[1], vn[1]) + qmul(vi[2], vn[2]), AMAX);
        if (!mode) begin
            t = clip(-2 * d, AMAX);
            for (int j = 0; j < 3; j++) rs[j] = clip(vi[j] + qmul(vn[j], t), CMAX);
        end else begin
            if (d > 0) begin
                c = d;
                for (int j = 0; j < 3; j++) vn[j] = -vn[j];
            end else begin
                c = -d;
            end
            k = clip(one - qmul(qmul(eta, eta), clip(one - qmul(c, c), AMAX)), AMAX);
            if (k < 0) begin
                s.ntr = 1'b1;
                rs = '{0, 0, 0};
            end else begin
                m = clip(qmul(eta, c) - qroot(k), AMAX);
                for (int j = 0; j < 3; j++)
                    rs[j] = clip(qmul(eta, vi[j]) + qmul(m, vn[j]), CMAX);
            end
        end
        s.x = rs[0][15:0];
        s.y = rs[1][15:0];
        s.z = rs[2][15:0];
        return s;
    endfunction

    assign o_pending = shade_q.size();

    always @(posedge i_clk) begin
        t_shade want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_valid && i_ready_in)
                shade_q.push_back(shade(i_mode, i_inc_x, i_inc_y, i_inc_z,
                                        i_nrm_x, i_nrm_y, i_nrm_z, longint'(i_eta)));
            if (i_out_valid && i_out_ready) begin
                if (shade_q.size() == 0) begin
                    $display("%0t: unexpected item x=%0d y=%0d z=%0d ntr=%0b", $time,
                             i_out_x, i_out_y, i_out_z, i_no_transmission);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = shade_q.pop_front();
                    if (want !== {i_out_x, i_out_y, i_out_z, i_no_transmission}) begin
                        $display({"%0t: expected x=%0d y=%0d z=%0d ntr=%0b, ",
                                  "got x=%0d y=%0d z=%0d ntr=%0b"},
                                 $time, want.x, want.y, want.z, want.ntr,
                                 i_out_x, i_out_y, i_out_z, i_no_transmission);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: dv/tb.sv
// Testbench top: drives rays into the vector unit and reports the verdict
`timescale 1ns / 100ps
module tb;
    logic i_clk, i_rst_n;
    logic i_valid, o_ready, i_mode, o_valid, i_ready, o_no_transmission;
    logic signed [15:0] i_inc_x, i_inc_y, i_inc_z, i_nrm_x, i_nrm_y, i_nrm_z;
    logic [15:0] i_eta;
    logic signed [15:0] o_out_x, o_out_y, o_out_z;
    int fail_count, pending, idle_cycles;
    bit calm, hold_off;

    reflect_refract_vector_unit uut (.*);

    rrv_tb_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_mode,
        .i_inc_x, .i_inc_y, .i_inc_z, .i_nrm_x, .i_nrm_y, .i_nrm_z, .i_eta,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_out_x(o_out_x), .i_out_y(o_out_y), .i_out_z(o_out_z),
        .i_no_transmission(o_no_transmission),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, one long hold-off, a calm stretch
    initial begin
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_ready <= 0;
                repeat (60) @(posedge i_clk);
                hold_off = 0;
            end
            i_ready <= calm || $urandom_range(99) >= 38;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [15:0] pick();
        case ($urandom_range(5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'(16'h4000 - 16'($urandom_range(16'h1000)));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(logic m, logic [15:0] ix, iy, iz, nx, ny, nz, et);
        i_valid <= 1;
        i_mode <= m;
        {i_inc_x, i_inc_y, i_inc_z} <= {ix, iy, iz};
        {i_nrm_x, i_nrm_y, i_nrm_z} <= {nx, ny, nz};
        i_eta <= et;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic gap();
        while (!calm && $urandom_range(99) < 38) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_ray();
        int sh;
        sh = $urandom_range(2);
        // mostly unit-ish vectors so refraction paths are reached
        if ($urandom_range(3) != 0)
            send(1'($urandom_range(1)),
                 16'($signed(16'($urandom)) >>> sh), 16'($signed(16'($urandom)) >>> sh),
                 16'($signed(16'($urandom)) >>> sh), 16'($signed(16'($urandom)) >>> 1),
                 16'($signed(16'($urandom)) >>> 1), 16'($signed(16'($urandom)) >>> 1),
                 16'($urandom_range(16'h6000, 16'h2000)));
        else
            send(1'($urandom_range(1)), pick(), pick(), pick(), pick(), pick(), pick(),
                 pick());
    endtask

    initial begin
        i_rst_n = 0; i_valid = 0; i_mode = 0; i_eta = 0;
        {i_inc_x, i_inc_y, i_inc_z, i_nrm_x, i_nrm_y, i_nrm_z} = '0;
        calm = 0; hold_off = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, tangent incidence, total internal reflection
        send(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
        send(1'b1, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff);
        send(1'b0, 16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000);
        send(1'b1, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h4000);
        send(1'b1, 16'h2d41, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h6000);
        send(1'b1, 16'h2d41, 16'hd2bf, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h3000);
        send(1'b1, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h5555);
        send(1'b1, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h3000);
        send(1'b0, 16'h0000, 16'hc000, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h1234);
        send(1'b1, 16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000);
        send(1'b1, 16'h1000, 16'h8000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'hffff);
        send(1'b1, 16'h3000, 16'h1000, 16'h2000, 16'h0000, 16'h0000, 16'h0000, 16'h8000);
        for (int n = 0; n < 400; n++) begin
            calm = (n >= 150 && n < 230);
            if (n == 300) hold_off = 1;
            gap();
            send_ray();
        end
        i_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
